### rtl/core/cci_pkg.sv
package cci_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int ANGLE_W  = 16;
  localparam int SPEED_W  = 32;
  localparam int IQ_W     = 32;
  localparam int EIDX_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int PCNT_W   = 9;
  localparam int GATE_W   = 31;
  localparam int LSB_W    = 24;
  localparam int GAIN_W   = 24;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMP_ENABLE = 3'd0,
    REG_SPEED_GATE  = 3'd1,
    REG_POINT_COUNT = 3'd2,
    REG_IQ_LSB      = 3'd3,
    REG_CALIB_GAIN  = 3'd4
  } cfg_reg_t;

  // Request kind carried in the input tuser
  localparam logic ACT_COMPENSATE = 1'b0;
  localparam logic ACT_WRITE      = 1'b1;

  // Table port controls from the pipeline to the sample store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic set_avail;
  } tbl_ctl_t;

endpackage

### rtl/core/cci_table.sv
module cci_table
  import cci_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tbl_ctl_t                   ctl,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic [IDX_W-1:0]           rd_addr0,
  input  logic [IDX_W-1:0]           rd_addr1,
  output logic signed [SAMPLE_W-1:0] rd_data0,
  output logic signed [SAMPLE_W-1:0] rd_data1,
  output logic                       avail
);

  logic signed [SAMPLE_W-1:0] mem [TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] rd0_r;
  logic signed [SAMPLE_W-1:0] rd1_r;
  logic                       avail_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd0_r <= mem[rd_addr0];
      rd1_r <= mem[rd_addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r <= 1'b0;
    end else if (ctl.set_avail) begin
      avail_r <= 1'b1;
    end
  end

  assign rd_data0 = rd0_r;
  assign rd_data1 = rd1_r;
  assign avail    = avail_r;

endmodule

### rtl/core/cogging_comp_interp_lut.sv
// Channel | Ports                | Contents
// in      | in_tvalid/in_tready  | tdata: angle, speed, target, entry index/value;
//         |                      | tuser: action; tlast: last_entry
// out     | out_tvalid/out_tready| tdata: iq_target_out, comp_current; tuser: comp_active
// cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data; always ready
//
// One request per cycle while the output is not stalled; a compensate request gives
// its result through eight register stages and the output register.
// The sample store has one write and two registered read ports, used in stage 2.
// Table write requests leave the pipeline after stage 2 and give no result.
// A stalled output holds; emptied stages keep filling, so input stays ready
// until every stage holds a request. Reset is synchronous and clears all valid bits.
module cogging_comp_interp_lut
  import cci_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: angle_turns, speed_ref, iq_target_in, entry_index, entry_value
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: action
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: iq_target_out, comp_current
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: comp_active
  output logic                  out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  function automatic logic signed [31:0] sat32_41(input logic signed [40:0] x);
    logic signed [31:0] r;
    if (x > 41'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -41'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // configuration
  logic                     comp_enable_r;
  logic [GATE_W-1:0]        speed_gate_r;
  logic [PCNT_W-1:0]        point_count_r;
  logic [LSB_W-1:0]         iq_lsb_r;
  logic signed [GAIN_W-1:0] calib_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_enable_r <= 1'b0;
      speed_gate_r  <= '0;
      point_count_r <= '0;
      iq_lsb_r      <= '0;
      calib_gain_r  <= 24'sd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COMP_ENABLE: comp_enable_r <= cfg_data[0];
        REG_SPEED_GATE:  speed_gate_r  <= cfg_data[GATE_W-1:0];
        REG_POINT_COUNT: point_count_r <= cfg_data[PCNT_W-1:0];
        REG_IQ_LSB:      iq_lsb_r      <= cfg_data[LSB_W-1:0];
        REG_CALIB_GAIN:  calib_gain_r  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // points in use, clamped to the store depth
  logic [PCNT_W-1:0] n_pts;
  assign n_pts = (32'(point_count_r) > TABLE_DEPTH) ? PCNT_W'(TABLE_DEPTH) : point_count_r;

  // stage valids and ready chain; rdy[9] is the output register
  logic [8:1] v_r;
  logic [9:1] rdy;
  logic       out_valid_r;

  assign rdy[9] = !out_valid_r || out_tready;
  always_comb begin
    for (int k = 1; k <= 8; k++) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end
  assign in_tready = rdy[1];

  // stage 1: request capture
  logic                       s1_act_r;
  logic [ANGLE_W-1:0]         s1_angle_r;
  logic signed [SPEED_W-1:0]  s1_speed_r;
  logic signed [IQ_W-1:0]     s1_iq_r;
  logic [EIDX_W-1:0]          s1_eidx_r;
  logic signed [SAMPLE_W-1:0] s1_eval_r;
  logic                       s1_last_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_act_r   <= in_tuser;
      s1_angle_r <= in_tdata[15:0];
      s1_speed_r <= in_tdata[47:16];
      s1_iq_r    <= in_tdata[79:48];
      s1_eidx_r  <= in_tdata[87:80];
      s1_eval_r  <= in_tdata[103:88];
      s1_last_r  <= in_tlast;
    end
  end

  logic [31:0] spd_abs;
  logic [24:0] pos_s1;
  logic        gate_s1;

  assign spd_abs = s1_speed_r[31] ? (~s1_speed_r + 32'd1) : s1_speed_r;
  assign pos_s1  = 25'(s1_angle_r) * 25'(n_pts);
  assign gate_s1 = comp_enable_r && (n_pts != '0) && (spd_abs <= {1'b0, speed_gate_r});

  // stage 2: index/fraction, store access
  logic                       s2_act_r;
  logic [PCNT_W-1:0]          s2_i0_r;
  logic [15:0]                s2_frac_r;
  logic                       s2_gate_r;
  logic signed [IQ_W-1:0]     s2_iq_r;
  logic [EIDX_W-1:0]          s2_eidx_r;
  logic signed [SAMPLE_W-1:0] s2_eval_r;
  logic                       s2_last_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_act_r  <= s1_act_r;
      s2_i0_r   <= pos_s1[24:16];
      s2_frac_r <= pos_s1[15:0];
      s2_gate_r <= gate_s1;
      s2_iq_r   <= s1_iq_r;
      s2_eidx_r <= s1_eidx_r;
      s2_eval_r <= s1_eval_r;
      s2_last_r <= s1_last_r;
    end
  end

  logic [PCNT_W:0]            i1_inc;
  logic [PCNT_W-1:0]          i1;
  tbl_ctl_t                   tctl;
  logic signed [SAMPLE_W-1:0] smp0;
  logic signed [SAMPLE_W-1:0] smp1;
  logic                       tbl_avail;

  // wrap the upper neighbour back to the first point
  assign i1_inc = {1'b0, s2_i0_r} + 10'd1;
  assign i1     = (i1_inc == {1'b0, n_pts}) ? '0 : i1_inc[PCNT_W-1:0];

  always_comb begin
    tctl.wr_en     = v_r[2] && (s2_act_r == ACT_WRITE) && rdy[3] &&
                     (32'(s2_eidx_r) < TABLE_DEPTH);
    tctl.set_avail = v_r[2] && (s2_act_r == ACT_WRITE) && rdy[3] && s2_last_r;
    tctl.rd_en     = v_r[2] && (s2_act_r == ACT_COMPENSATE) && rdy[3];
  end

  cci_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tctl),
    .wr_addr  (IDX_W'(s2_eidx_r)),
    .wr_data  (s2_eval_r),
    .rd_addr0 (IDX_W'(s2_i0_r)),
    .rd_addr1 (IDX_W'(i1)),
    .rd_data0 (smp0),
    .rd_data1 (smp1),
    .avail    (tbl_avail)
  );

  // stage 3: interpolate
  logic                   s3_act_r;
  logic [15:0]            s3_frac_r;
  logic signed [IQ_W-1:0] s3_iq_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_act_r  <= s2_gate_r && tbl_avail;
      s3_frac_r <= s2_frac_r;
      s3_iq_r   <= s2_iq_r;
    end
  end

  logic signed [16:0] diff_s3;
  logic signed [33:0] fprod_s3;
  logic signed [33:0] c_s3;

  assign diff_s3  = 17'(smp1) - 17'(smp0);
  assign fprod_s3 = $signed({1'b0, s3_frac_r}) * diff_s3;
  assign c_s3     = (34'(smp0) <<< 16) + fprod_s3;

  // stage 4: scale by amps per count
  logic                   s4_act_r;
  logic signed [32:0]     s4_c_r;
  logic signed [IQ_W-1:0] s4_iq_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_act_r <= s3_act_r;
      s4_c_r   <= c_s3[32:0];
      s4_iq_r  <= s3_iq_r;
    end
  end

  logic signed [57:0] lprod_s4;
  assign lprod_s4 = s4_c_r * $signed({1'b0, iq_lsb_r});

  // stage 5: round off 24 fraction bits
  logic                   s5_act_r;
  logic signed [57:0]     s5_p_r;
  logic signed [IQ_W-1:0] s5_iq_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_act_r <= s4_act_r;
      s5_p_r   <= lprod_s4;
      s5_iq_r  <= s4_iq_r;
    end
  end

  logic signed [57:0] lrnd_s5;
  assign lrnd_s5 = s5_p_r + 58'sd8388608;

  // stage 6: apply gain
  logic                   s6_act_r;
  logic signed [32:0]     s6_a_r;
  logic signed [IQ_W-1:0] s6_iq_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_act_r <= s5_act_r;
      s6_a_r   <= lrnd_s5[56:24];
      s6_iq_r  <= s5_iq_r;
    end
  end

  logic signed [56:0] gprod_s6;
  assign gprod_s6 = s6_a_r * calib_gain_r;

  // stage 7: round off 16 fraction bits and saturate
  logic                   s7_act_r;
  logic signed [56:0]     s7_p_r;
  logic signed [IQ_W-1:0] s7_iq_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_act_r <= s6_act_r;
      s7_p_r   <= gprod_s6;
      s7_iq_r  <= s6_iq_r;
    end
  end

  logic signed [56:0] grnd_s7;
  logic signed [31:0] comp_s7;
  assign grnd_s7 = s7_p_r + 57'sd32768;
  assign comp_s7 = s7_act_r ? sat32_41(grnd_s7[56:16]) : 32'sd0;

  // stage 8: add to target
  logic                   s8_act_r;
  logic signed [31:0]     s8_comp_r;
  logic signed [IQ_W-1:0] s8_iq_r;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_act_r  <= s7_act_r;
      s8_comp_r <= comp_s7;
      s8_iq_r   <= s7_iq_r;
    end
  end

  logic signed [32:0] sum_s8;
  logic signed [31:0] iq_s8;
  assign sum_s8 = 33'(s8_iq_r) + 33'(s8_comp_r);
  assign iq_s8  = sat32_41(41'(sum_s8));

  // output register
  logic        out_act_r;
  logic [31:0] out_comp_r;
  logic [31:0] out_iq_r;

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      out_act_r  <= s8_act_r;
      out_comp_r <= s8_comp_r;
      out_iq_r   <= iq_s8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[1]) v_r[1] <= in_tvalid;
      if (rdy[2]) v_r[2] <= v_r[1];
      // drop table writes here: they give no result
      if (rdy[3]) v_r[3] <= v_r[2] && (s2_act_r == ACT_COMPENSATE);
      if (rdy[4]) v_r[4] <= v_r[3];
      if (rdy[5]) v_r[5] <= v_r[4];
      if (rdy[6]) v_r[6] <= v_r[5];
      if (rdy[7]) v_r[7] <= v_r[6];
      if (rdy[8]) v_r[8] <= v_r[7];
      if (rdy[9]) out_valid_r <= v_r[8];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_comp_r, out_iq_r};
  assign out_tuser  = out_act_r;

endmodule

### rtl/core/cci_chk.sv
module cci_chk
  import cci_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tuser,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic                  cfg_valid,
  input logic                  cfg_ready
);

  // compensate requests accepted but not yet answered
  logic [4:0] pend_r;
  logic [4:0] pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready && (in_tuser == ACT_COMPENSATE);
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc && pend_r != 5'd31) begin
      pend_nxt = pend_r + 5'd1;
    end else if (!in_acc && out_acc && pend_r != 5'd0) begin
      pend_nxt = pend_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 5'd0)
    else $error("result with no request outstanding");

  a_idle_comp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[63:32] == 32'd0)
    else $error("inactive result carries compensation");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind cogging_comp_interp_lut cci_chk u_cci_chk (.*);
